### hw/rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the RGB to HSV converter
// Pixel field widths, hue sector codes and the data word that travels
// through the chain of divider cells.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int unsigned ChanW = 8;   // width of one color channel
    localparam int unsigned HueW  = 9;   // hue in degrees, 0..359
    localparam int unsigned QuoW  = 8;   // quotient bits, one per cell
    localparam int unsigned RemW  = 16;  // dividend / partial remainder width

    localparam logic [HueW-1:0]  HueBaseRed   = 9'd0;
    localparam logic [HueW-1:0]  HueBaseGreen = 9'd120;
    localparam logic [HueW-1:0]  HueBaseBlue  = 9'd240;
    localparam logic [HueW:0]    HueFull      = 10'd360;

    // Sector selected by the largest channel
    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } hue_sector_t;

    // One lane of the restoring divider
    typedef struct packed {
        logic [RemW-1:0]  rem;  // partial remainder
        logic [ChanW-1:0] dvs;  // divisor
        logic [QuoW-1:0]  quo;  // quotient bits found so far
    } div_lane_t;

    // Word handed from cell to cell
    typedef struct packed {
        div_lane_t        sat;        // delta*255 / max
        div_lane_t        hue;        // |diff|*60 / delta
        hue_sector_t      sector;
        logic             neg;        // channel difference was negative
        logic [ChanW-1:0] brightness;
    } cell_data_t;

endpackage

### hw/rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGB to HSV pixel converter
// Converts one pixel per clock into hue, saturation and brightness unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one RGB pixel per request, m_ channel returns one HSV
//   result per pixel, in order.
//   From an accepted request to m_tvalid a pixel passes one analysis stage,
//   a chain of 8 divider cells (one quotient bit each, saturation and hue
//   division side by side) and one output register.
//   Throughput is one pixel per clock unless m_tready stalls the chain; each
//   stage has its own valid bit, so bubbles close up and a new request is taken
//   while a result waits. When the receiver stalls, the chain fills up stage by
//   stage and s_tready drops only once every stage holds a pixel.
//   Reset (aresetn low, synchronous) empties all stages; no clearing pass.
//   Grey and black pixels give hue 0 and saturation 0.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue[8:0], saturation[16:9], brightness[24:17]
);

    localparam int unsigned Cells = hsv_pkg::QuoW;

    logic                chain_valid [Cells+1];
    logic                chain_ready [Cells+1];
    hsv_pkg::cell_data_t chain_data  [Cells+1];

    // Analysis stage
    hsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < Cells; k++) begin : g_cell
        hsv_div_cell #(
            .BIT_IDX (Cells - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // Hue assembly and output register
    hsv_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[Cells]),
        .in_ready (chain_ready[Cells]),
        .in_data  (chain_data[Cells]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hw/rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front: pixel analysis stage
// Finds max, min and the hue sector, forms both dividends and registers
// the word that enters the divider chain.
// ----------------------------------------------------------------------------
module hsv_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                out_valid,
    input  logic                out_ready,
    output hsv_pkg::cell_data_t out_data
);

    logic                valid_reg;
    hsv_pkg::cell_data_t data_reg;
    hsv_pkg::cell_data_t data_next;

    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] delta;
    logic [8:0] diff;
    logic [7:0] mag;

    // Sector, max/min and signed channel difference
    always_comb begin
        data_next = '0;
        if (red >= green && red >= blue) begin
            hi               = red;
            data_next.sector = hsv_pkg::SECTOR_RED;
            diff             = {1'b0, green} - {1'b0, blue};
        end else if (green >= blue) begin
            hi               = green;
            data_next.sector = hsv_pkg::SECTOR_GREEN;
            diff             = {1'b0, blue} - {1'b0, red};
        end else begin
            hi               = blue;
            data_next.sector = hsv_pkg::SECTOR_BLUE;
            diff             = {1'b0, red} - {1'b0, green};
        end
        lo = (red <= green) ? red : green;
        lo = (blue <= lo) ? blue : lo;
        delta = hi - lo;
        mag   = diff[8] ? 8'(-diff) : diff[7:0];

        // delta*255 and |diff|*60 by shift and subtract
        data_next.sat.rem    = {delta, 8'd0} - {8'd0, delta};
        data_next.sat.dvs    = hi;
        data_next.sat.quo    = '0;
        data_next.hue.rem    = {2'b00, mag, 6'd0} - {6'd0, mag, 2'd0};
        data_next.hue.dvs    = delta;
        data_next.hue.quo    = '0;
        data_next.neg        = diff[8];
        data_next.brightness = hi;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/hsv_div_cell.sv
// ----------------------------------------------------------------------------
// hsv_div_cell: one restoring-division cell
// Resolves quotient bit BIT_IDX of both the saturation and the hue
// division and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module hsv_div_cell #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsv_pkg::cell_data_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hsv_pkg::cell_data_t out_data
);

    logic                valid_reg;
    hsv_pkg::cell_data_t data_reg;
    hsv_pkg::cell_data_t data_next;

    logic [hsv_pkg::RemW-1:0] sat_shift;
    logic [hsv_pkg::RemW-1:0] hue_shift;

    // Trial subtract of the divisor aligned to this bit
    always_comb begin
        data_next = in_data;
        sat_shift = hsv_pkg::RemW'(in_data.sat.dvs) << BIT_IDX;
        hue_shift = hsv_pkg::RemW'(in_data.hue.dvs) << BIT_IDX;
        if (in_data.sat.dvs != '0 && in_data.sat.rem >= sat_shift) begin
            data_next.sat.rem          = in_data.sat.rem - sat_shift;
            data_next.sat.quo[BIT_IDX] = 1'b1;
        end
        if (in_data.hue.dvs != '0 && in_data.hue.rem >= hue_shift) begin
            data_next.hue.rem          = in_data.hue.rem - hue_shift;
            data_next.hue.quo[BIT_IDX] = 1'b1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/hsv_post.sv
// ----------------------------------------------------------------------------
// hsv_post: hue assembly and output register
// Adds the sector base to the signed hue quotient, wraps negative hue
// and holds the result request for the receiver.
// ----------------------------------------------------------------------------
module hsv_post (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsv_pkg::cell_data_t in_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    logic       valid_reg;
    logic [8:0] hue_reg;
    logic [8:0] hue_next;
    logic [7:0] sat_reg;
    logic [7:0] bright_reg;
    logic [8:0] base;
    logic [8:0] quo;
    logic [9:0] wrapped;

    // Base plus or minus quotient, negative results wrap by 360
    always_comb begin
        case (in_data.sector)
            hsv_pkg::SECTOR_RED:   base = hsv_pkg::HueBaseRed;
            hsv_pkg::SECTOR_GREEN: base = hsv_pkg::HueBaseGreen;
            hsv_pkg::SECTOR_BLUE:  base = hsv_pkg::HueBaseBlue;
            default:               base = hsv_pkg::HueBaseRed;
        endcase
        quo     = {1'b0, in_data.hue.quo};
        wrapped = {1'b0, base} + hsv_pkg::HueFull - {1'b0, quo};
        if (!in_data.neg) begin
            hue_next = base + quo;
        end else if (base >= quo) begin
            hue_next = base - quo;
        end else begin
            hue_next = wrapped[8:0];
        end
    end

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, bright_reg, sat_reg, hue_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hue_reg    <= hue_next;
            sat_reg    <= in_data.sat.quo;
            bright_reg <= in_data.brightness;
        end
    end

endmodule

### hw/rtl/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker: port-level checks for the RGB to HSV converter
// Watches the result channel for handshake and value rules.
// ----------------------------------------------------------------------------
module hsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // No result request right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result request holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Hue stays within 0..359
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:0] < 9'd360)
        else $error("hue out of range");

    // Black pixel gives zero hue and saturation
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24:17] == 8'd0 |-> m_tdata[16:0] == 17'd0)
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter hsv_checker u_hsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
